// File: rtl/rwa_pkg.sv
// Shared constants and controller/datapath interface types for the running window average.
`default_nettype none

package rwa_pkg;

    localparam int MAX_WINDOW   = 64;  // default depth of the sample ring
    localparam int WINDOW_RESET = 64;  // window length after reset, before clamping
    localparam int SAMPLE_W     = 32;
    localparam int CFG_W        = 7;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // take the input word, fetch the oldest sample
        logic update;    // update ring, sum, fill count; load the divider
        logic step;      // one restoring division step
        logic load;      // move the quotient into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;  // the current step is the last one
        logic out_free;  // output register can take a word this cycle
    } t_status;

endpackage

`default_nettype wire

// File: rtl/rwa_ctrl.sv
// Sequencer for the running window average: accept, fetch, update, divide, deliver.
`default_nettype none

module rwa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire rwa_pkg::t_status i_status,
    output rwa_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the quotient until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rwa_datapath.sv
// Sample ring, running sum, fill tracking, bit-serial divider and output register.
`default_nettype none

module rwa_datapath #(
    parameter int MAX_WINDOW = rwa_pkg::MAX_WINDOW
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rwa_pkg::t_cmd                i_cmd,
    output rwa_pkg::t_status                  o_status,
    input  wire logic [rwa_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rwa_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [rwa_pkg::SAMPLE_W-1:0]      o_average,
    output logic                              o_window_full
);

    localparam int SW       = rwa_pkg::SAMPLE_W;
    localparam int CFG_MAX  = (1 << rwa_pkg::CFG_W) - 1;
    localparam int LEN_MAX  = (MAX_WINDOW < CFG_MAX) ? MAX_WINDOW : CFG_MAX;
    localparam int LEN_RST  = (rwa_pkg::WINDOW_RESET > LEN_MAX) ? LEN_MAX
                                                                 : rwa_pkg::WINDOW_RESET;
    localparam int LEN_W    = $clog2(LEN_MAX + 1);
    localparam int PTR_W    = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
    localparam int SUM_W    = SW + $clog2(LEN_MAX);
    localparam int CNT_W    = $clog2(SUM_W);

    logic [SW-1:0]    r_ring [LEN_MAX];

    logic [LEN_W-1:0] r_len,  n_len;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [PTR_W-1:0] r_pos,  n_pos;
    logic [SUM_W-1:0] r_sum,  n_sum;
    logic [SW-1:0]    r_sample;
    logic [SW-1:0]    r_old;
    logic [LEN_W-1:0] r_div,  n_div;
    logic [LEN_W-1:0] r_rem,  n_rem;
    logic [SUM_W-1:0] r_quo,  n_quo;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_full, n_full;
    logic             r_out_valid, n_out_valid;
    logic [SW-1:0]    r_out_avg;
    logic             r_out_full;

    logic             was_full;
    logic [LEN_W-1:0] fill_inc;
    logic [LEN_W-1:0] pos_inc;
    logic [LEN_W:0]   trial;
    logic             trial_ge;
    logic [LEN_W-1:0] cfg_len;

    always_comb begin
        // clamp the written length into 1..LEN_MAX
        if (i_cfg_wr_data == '0) begin
            cfg_len = LEN_W'(1);
        end else if (i_cfg_wr_data > rwa_pkg::CFG_W'(LEN_MAX)) begin
            cfg_len = LEN_W'(LEN_MAX);
        end else begin
            cfg_len = LEN_W'(i_cfg_wr_data);
        end

        was_full = (r_fill >= r_len);
        fill_inc = r_fill + LEN_W'(1);
        pos_inc  = LEN_W'(r_pos) + LEN_W'(1);
        trial    = {r_rem, r_quo[SUM_W-1]};
        trial_ge = (trial >= {1'b0, r_div});

        n_len  = r_len;
        n_fill = r_fill;
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_div  = r_div;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_full = r_full;

        if (i_cfg_wr_en) begin
            n_len  = cfg_len;
            n_fill = '0;
            n_pos  = '0;
            n_sum  = '0;
        end else if (i_cmd.update) begin
            // drop the oldest sample once the window is full, add the new one
            n_sum  = r_sum - (was_full ? SUM_W'(r_old) : '0) + SUM_W'(r_sample);
            n_fill = was_full ? r_fill : fill_inc;
            n_full = was_full || (fill_inc >= r_len);
            n_div  = was_full ? r_len : fill_inc;
            n_pos  = (pos_inc >= r_len) ? '0 : PTR_W'(pos_inc);
            n_quo  = n_sum;
            n_rem  = '0;
            n_cnt  = '0;
        end else if (i_cmd.step) begin
            n_rem = trial_ge ? LEN_W'(trial - {1'b0, r_div}) : trial[LEN_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], trial_ge};
            n_cnt = r_cnt + CNT_W'(1);
        end

        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_W'(LEN_RST);
            r_fill      <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_full <= n_full;
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.load) begin
            r_out_avg  <= r_quo[SW-1:0];
            r_out_full <= r_full;
        end
    end

    // ring: entries past the fill count are never used, so no clearing is needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_old <= r_ring[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_pos] <= r_sample;
        end
    end

    assign o_status.div_last = (r_cnt == CNT_W'(SUM_W - 1));
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_average     = r_out_avg;
    assign o_window_full = r_out_full;

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("fill count beyond window length");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_pos) < r_len)
        else $error("write position beyond window length");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < r_div) && (r_div != '0))
        else $error("divider remainder out of range");

    a_update_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> i_cmd.step && (r_cnt == '0))
        else $error("division did not start after update");

endmodule

`default_nettype wire

// File: rtl/running_window_average_top.sv
// Running window average: one sample word in, one truncated mean word out, with a fill flag.
// While a sample word is accepted, the oldest sample is fetched from the ring memory. Then
// the ring, sum and fill count are updated and the one-bit-per-cycle restoring divider
// forms the SUM_W-bit quotient (SUM_W = 32 + clog2(depth) = 38 at the default depth 64),
// which waits for a free output register. The next sample word is taken while
// a finished result still waits in that register. A write on the configuration port sets
// the window length (0 is taken as 1, values past the depth saturate) and empties the
// window; write it only while no sample word is in flight. No clearing pass follows reset.
`default_nettype none

module running_window_average_top #(
    parameter int MAX_WINDOW = rwa_pkg::MAX_WINDOW
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rwa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [rwa_pkg::SAMPLE_W-1:0]      o_average,
    output logic                              o_window_full,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rwa_pkg::CFG_W-1:0]    i_cfg_wr_data
);

    rwa_pkg::t_cmd    cmd;
    rwa_pkg::t_status status;

    rwa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rwa_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_sample),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_average     (o_average),
        .o_window_full (o_window_full)
    );

endmodule

`default_nettype wire
